// ===== sv/ctpe_pkg.sv =====
// Package for the truncated Coulomb pair energy unit.
// Holds request/result types, pipeline sideband types and fixed constants.
// No dependencies.
package ctpe_pkg;

  localparam int DIST_W   = 32;
  localparam int CHG_W    = 16;
  localparam int ENERGY_W = 48;
  localparam int LB_W     = 24;
  localparam int CSQ_W    = 32;
  localparam int CINV_W   = 24;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 32;

  localparam int PROD_W   = 2 * CHG_W;
  localparam int CMAG_W   = PROD_W - 1;
  localparam int MAG_W    = LB_W + CMAG_W;
  localparam int RAD_W    = DIST_W + 16;
  localparam int R_W      = RAD_W / 2;
  localparam int SQ_N     = R_W;
  localparam int SQ_REM_W = R_W + 2;
  localparam int QP_W     = R_W + CINV_W;
  localparam int Q_W      = 25;
  localparam int PW_N     = 6;
  localparam int PL_N     = PW_N + 3;
  localparam int P_W      = 32;
  localparam int PM_W     = 29;
  localparam int NUM_W    = MAG_W + 8;
  localparam int DV_N     = NUM_W;
  localparam int HI_W     = NUM_W - 32;
  localparam int PA_W     = HI_W + PM_W;
  localparam int PB_W     = 32 + PM_W;
  localparam int SUM_W    = PA_W + 32;
  localparam int EM_W     = SUM_W - 40;

  localparam logic [Q_W-1:0] ONE_Q24 = Q_W'(1) << 24;

  localparam logic [LB_W-1:0]   LB_RST   = LB_W'(466961);
  localparam logic [CSQ_W-1:0]  CSQ_RST  = '1;
  localparam logic [CINV_W-1:0] CINV_RST = '0;

  localparam logic [ENERGY_W-1:0] E_POS_MAX = {1'b0, {(ENERGY_W-1){1'b1}}};
  localparam logic [ENERGY_W-1:0] E_NEG_MIN = {1'b1, {(ENERGY_W-1){1'b0}}};
  localparam logic [EM_W-1:0]     EM_POS_LIM = EM_W'(E_POS_MAX);
  localparam logic [EM_W-1:0]     EM_NEG_LIM = EM_W'(E_NEG_MIN);

  // configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_BJERRUM_LENGTH = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_CUTOFF_SQ      = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_CUTOFF_INV     = 2'd2;

  typedef struct packed {
    logic        [DIST_W-1:0] dist_sq;
    logic signed [CHG_W-1:0]  charge_a;
    logic signed [CHG_W-1:0]  charge_b;
  } ctpe_in_t;

  typedef struct packed {
    logic signed [ENERGY_W-1:0] energy;
    logic                       inside_cutoff;
    logic                       saturated;
  } ctpe_out_t;

  // sideband through the square root stages
  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             cneg;
    logic             in_range;
    logic             zero;
  } sq_side_t;

  // sideband through the divider stages
  typedef struct packed {
    logic [PM_W-1:0] pm;
    logic            neg;
    logic            cneg;
    logic            mag_nz;
    logic            in_range;
    logic            zero;
  } dv_side_t;

endpackage

// ===== sv/truncated_coulomb_pair_energy_unit.sv =====
// Truncated Coulomb pair energy unit, top level.
// Accepts one request per cycle while no result waits in the skid entry.
// Depth is set by the 24-stage square root and the 63-stage divider.
// A skid entry behind the result register takes one result when the output stalls;
// the input then stalls until the skid entry drains.
// Reset (rst_n, synchronous, active low) clears all valid bits and loads config defaults.
// Depends on ctpe_pkg, ctpe_sqrt, ctpe_poly, ctpe_div.
module truncated_coulomb_pair_energy_unit import ctpe_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ctpe_in_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ctpe_out_t         out_data,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  // ---------------- configuration registers ----------------
  logic [LB_W-1:0]   bjerrum_r;
  logic [CSQ_W-1:0]  cutoff_sq_r;
  logic [CINV_W-1:0] cutoff_inv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bjerrum_r    <= LB_RST;
      cutoff_sq_r  <= CSQ_RST;
      cutoff_inv_r <= CINV_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_BJERRUM_LENGTH: bjerrum_r    <= cfg_wdata[LB_W-1:0];
        CFG_CUTOFF_SQ:      cutoff_sq_r  <= cfg_wdata[CSQ_W-1:0];
        CFG_CUTOFF_INV:     cutoff_inv_r <= cfg_wdata[CINV_W-1:0];
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  // ---------------- global pipeline enable ----------------
  // The whole pipe moves unless the skid entry is holding a result.
  logic skid_vld_r;
  logic en;
  assign en       = ~skid_vld_r;
  assign in_ready = en;

  // ---------------- S0: cutoff test, charge product ----------------
  logic signed [PROD_W-1:0] cprod;
  logic                     s0_vld_r;
  logic [DIST_W-1:0]        s0_r2_r;
  logic [CMAG_W-1:0]        s0_cmag_r;
  logic                     s0_cneg_r, s0_inside_r, s0_zero_r;

  assign cprod = in_data.charge_a * in_data.charge_b;

  // ---------------- S1: lB * |qa*qb| ----------------
  logic              s1_vld_r;
  logic [DIST_W-1:0] s1_r2_r;
  sq_side_t          s1_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_valid;
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r2_r     <= in_data.dist_sq;
      s0_cneg_r   <= cprod[PROD_W-1];
      s0_cmag_r   <= cprod[PROD_W-1] ? CMAG_W'(-cprod) : CMAG_W'(cprod);
      // all-ones squared cutoff disables the cutoff
      s0_inside_r <= (cutoff_sq_r == CSQ_RST) || (in_data.dist_sq < cutoff_sq_r);
      s0_zero_r   <= (in_data.dist_sq == '0);

      s1_r2_r            <= s0_r2_r;
      s1_side_r.mag      <= bjerrum_r * s0_cmag_r;
      s1_side_r.cneg     <= s0_cneg_r;
      s1_side_r.in_range <= s0_inside_r;
      s1_side_r.zero     <= s0_zero_r;
    end
  end

  // ---------------- r = sqrt(dist_sq), Q8.16 ----------------
  logic           sq_vld;
  logic [R_W-1:0] sq_root;
  sq_side_t       sq_side;

  ctpe_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s1_vld_r),
    .in_rad   (s1_r2_r),
    .in_side  (s1_side_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  // ---------------- S(q) ----------------
  logic             pl_vld;
  logic [R_W-1:0]   pl_r;
  logic [MAG_W-1:0] pl_mag;
  dv_side_t         pl_side;

  ctpe_poly u_poly (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .cfg_inv  (cutoff_inv_r),
    .in_vld   (sq_vld),
    .in_r     (sq_root),
    .in_side  (sq_side),
    .out_vld  (pl_vld),
    .out_r    (pl_r),
    .out_mag  (pl_mag),
    .out_side (pl_side)
  );

  // ---------------- D = (M << 8) / r ----------------
  logic             dv_vld;
  logic [NUM_W-1:0] dv_quot;
  dv_side_t         dv_side;

  ctpe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (pl_vld),
    .in_num   ({pl_mag, 8'h00}),
    .in_den   (pl_r),
    .in_side  (pl_side),
    .out_vld  (dv_vld),
    .out_quot (dv_quot),
    .out_side (dv_side)
  );

  // ---------------- F1/F2: |E| = D*|S| >> 40, split in two partial products ----------------
  logic            f1_vld_r, f2_vld_r;
  logic [PA_W-1:0] f1_a_r;
  logic [PB_W-1:0] f1_b_r;
  dv_side_t        f1_side_r, f2_side_r;
  logic [EM_W-1:0] f2_em_r;
  logic [SUM_W-1:0] f_sum;

  assign f_sum = {f1_a_r, 32'h0} + SUM_W'(f1_b_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
    end else if (en) begin
      f1_vld_r <= dv_vld;
      f2_vld_r <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_a_r    <= dv_quot[NUM_W-1:32] * dv_side.pm;
      f1_b_r    <= dv_quot[31:0] * dv_side.pm;
      f1_side_r <= dv_side;
      f2_em_r   <= f_sum[SUM_W-1:40];
      f2_side_r <= f1_side_r;
    end
  end

  // ---------------- sign, saturation, special cases ----------------
  ctpe_out_t res;

  always_comb begin
    res = '0;
    if (f2_side_r.in_range) begin
      res.inside_cutoff = 1'b1;
      if (f2_side_r.zero) begin
        // zero distance: clip to the extreme with the sign of lB*qa*qb
        res.saturated = 1'b1;
        if (f2_side_r.mag_nz) res.energy = f2_side_r.cneg ? E_NEG_MIN : E_POS_MAX;
      end else if (f2_side_r.neg) begin
        if (f2_em_r > EM_NEG_LIM) begin
          res.energy    = E_NEG_MIN;
          res.saturated = 1'b1;
        end else begin
          res.energy = ENERGY_W'(-f2_em_r);
        end
      end else begin
        if (f2_em_r > EM_POS_LIM) begin
          res.energy    = E_POS_MAX;
          res.saturated = 1'b1;
        end else begin
          res.energy = ENERGY_W'(f2_em_r);
        end
      end
    end
  end

  // ---------------- result register + skid entry ----------------
  logic      out_vld_r;
  ctpe_out_t out_data_r, skid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_ready) skid_vld_r <= 1'b0;
    end else if (f2_vld_r) begin
      if (out_vld_r && !out_ready) skid_vld_r <= 1'b1;
      else                         out_vld_r  <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_ready) out_data_r <= skid_r;
    end else if (f2_vld_r) begin
      if (out_vld_r && !out_ready) skid_r     <= res;
      else                         out_data_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/ctpe_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
// Depends on ctpe_pkg.
module ctpe_sqrt import ctpe_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [DIST_W-1:0] in_rad,
  input  sq_side_t          in_side,
  output logic              out_vld,
  output logic [R_W-1:0]    out_root,
  output sq_side_t          out_side
);

  logic                vld_r  [SQ_N];
  sq_side_t            side_r [SQ_N];
  logic [RAD_W-1:0]    rad_r  [SQ_N];
  logic [SQ_REM_W-1:0] rem_r  [SQ_N];
  logic [R_W-1:0]      root_r [SQ_N];
  logic [RAD_W-1:0]    rad_nxt  [SQ_N];
  logic [SQ_REM_W-1:0] rem_nxt  [SQ_N];
  logic [R_W-1:0]      root_nxt [SQ_N];

  always_comb begin
    logic [RAD_W-1:0]    rad_i;
    logic [SQ_REM_W-1:0] rem_i;
    logic [R_W-1:0]      root_i;
    logic [SQ_REM_W+1:0] t;
    logic [SQ_REM_W+1:0] d;
    for (int k = 0; k < SQ_N; k++) begin
      if (k == 0) begin
        rad_i  = {in_rad, {(RAD_W-DIST_W){1'b0}}};
        rem_i  = '0;
        root_i = '0;
      end else begin
        rad_i  = rad_r[k-1];
        rem_i  = rem_r[k-1];
        root_i = root_r[k-1];
      end
      t = {rem_i, rad_i[RAD_W-1 -: 2]};
      d = {2'b00, root_i, 2'b01};
      if (t >= d) begin
        rem_nxt[k]  = SQ_REM_W'(t - d);
        root_nxt[k] = {root_i[R_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = t[SQ_REM_W-1:0];
        root_nxt[k] = {root_i[R_W-2:0], 1'b0};
      end
      rad_nxt[k] = {rad_i[RAD_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQ_N; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int k = 1; k < SQ_N; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      for (int k = 1; k < SQ_N; k++) side_r[k] <= side_r[k-1];
      for (int k = 0; k < SQ_N; k++) begin
        rad_r[k]  <= rad_nxt[k];
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
      end
    end
  end

  assign out_vld  = vld_r[SQ_N-1];
  assign out_root = root_r[SQ_N-1];
  assign out_side = side_r[SQ_N-1];

endmodule

// ===== sv/ctpe_poly.sv =====
// Pipelined cutoff polynomial: q = r*cutoff_inv, powers of q, then S(q).
// Depends on ctpe_pkg.
module ctpe_poly import ctpe_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [CINV_W-1:0] cfg_inv,
  input  logic              in_vld,
  input  logic [R_W-1:0]    in_r,
  input  sq_side_t          in_side,
  output logic              out_vld,
  output logic [R_W-1:0]    out_r,
  output logic [MAG_W-1:0]  out_mag,
  output dv_side_t          out_side
);

  logic           vld_r  [PL_N];
  logic [R_W-1:0] r_r    [PL_N];
  sq_side_t       side_r [PL_N];

  logic [QP_W-1:0] prod_r;
  logic [Q_W-1:0]  q_r;
  logic [Q_W-1:0]  cur_r [PW_N];
  logic [Q_W-1:0]  qq_r  [PW_N];
  logic [Q_W-1:0]  q5_r  [PW_N];
  logic [Q_W-1:0]  q6_r  [PW_N];
  logic [Q_W-1:0]  cur_nxt [PW_N];
  logic [Q_W-1:0]  q5_nxt  [PW_N];
  logic [Q_W-1:0]  q6_nxt  [PW_N];
  logic [PM_W-1:0] pm_r;
  logic            psgn_r;

  logic [QP_W-17:0] qraw;
  logic [Q_W-1:0]   q_nxt;
  logic [P_W-1:0]   pos_s, neg_s, p_s;

  assign qraw  = prod_r[QP_W-1:16];
  assign q_nxt = (qraw > (QP_W-16)'(ONE_Q24)) ? ONE_Q24 : qraw[Q_W-1:0];

  always_comb begin
    logic [Q_W-1:0]   src_cur, src_q;
    logic [2*Q_W-1:0] m;
    for (int j = 0; j < PW_N; j++) begin
      src_cur    = (j == 0) ? q_r : cur_r[(j == 0) ? 0 : j-1];
      src_q      = (j == 0) ? q_r : qq_r[(j == 0) ? 0 : j-1];
      m          = src_cur * src_q;
      cur_nxt[j] = m[Q_W+23:24];
      if (j == 3)      q5_nxt[j] = cur_nxt[j];
      else if (j == 0) q5_nxt[j] = '0;
      else             q5_nxt[j] = q5_r[j-1];
      if (j == 4)      q6_nxt[j] = cur_nxt[j];
      else if (j == 0) q6_nxt[j] = '0;
      else             q6_nxt[j] = q6_r[j-1];
    end
  end

  // S = 1 + 5.25q^5 + 2.5q^7 - 1.75q - 7q^6, Q.24
  assign pos_s = P_W'(ONE_Q24) + ((P_W'(q5_r[PW_N-1]) * P_W'(21)) >> 2)
               + ((P_W'(cur_r[PW_N-1]) * P_W'(5)) >> 1);
  assign neg_s = ((P_W'(qq_r[PW_N-1]) * P_W'(7)) >> 2) + P_W'(q6_r[PW_N-1]) * P_W'(7);
  assign p_s   = pos_s - neg_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PL_N; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int k = 1; k < PL_N; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]    <= in_r;
      side_r[0] <= in_side;
      for (int k = 1; k < PL_N; k++) begin
        r_r[k]    <= r_r[k-1];
        side_r[k] <= side_r[k-1];
      end
      prod_r <= in_r * cfg_inv;
      q_r    <= q_nxt;
      for (int j = 0; j < PW_N; j++) begin
        cur_r[j] <= cur_nxt[j];
        qq_r[j]  <= (j == 0) ? q_r : qq_r[(j == 0) ? 0 : j-1];
        q5_r[j]  <= q5_nxt[j];
        q6_r[j]  <= q6_nxt[j];
      end
      psgn_r <= p_s[P_W-1];
      pm_r   <= p_s[P_W-1] ? PM_W'(-p_s) : PM_W'(p_s);
    end
  end

  assign out_vld           = vld_r[PL_N-1];
  assign out_r             = r_r[PL_N-1];
  assign out_mag           = side_r[PL_N-1].mag;
  assign out_side.pm       = pm_r;
  assign out_side.neg      = side_r[PL_N-1].cneg ^ psgn_r;
  assign out_side.cneg     = side_r[PL_N-1].cneg;
  assign out_side.mag_nz   = |side_r[PL_N-1].mag;
  assign out_side.in_range = side_r[PL_N-1].in_range;
  assign out_side.zero     = side_r[PL_N-1].zero;

endmodule

// ===== sv/ctpe_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on ctpe_pkg.
module ctpe_div import ctpe_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [NUM_W-1:0] in_num,
  input  logic [R_W-1:0]   in_den,
  input  dv_side_t         in_side,
  output logic             out_vld,
  output logic [NUM_W-1:0] out_quot,
  output dv_side_t         out_side
);

  logic             vld_r  [DV_N];
  dv_side_t         side_r [DV_N];
  logic [R_W-1:0]   den_r  [DV_N];
  logic [R_W-1:0]   rem_r  [DV_N];
  logic [NUM_W-1:0] qd_r   [DV_N];
  logic [R_W-1:0]   rem_nxt [DV_N];
  logic [NUM_W-1:0] qd_nxt  [DV_N];

  always_comb begin
    logic [R_W-1:0]   den_i, rem_i;
    logic [NUM_W-1:0] qd_i;
    logic [R_W:0]     t;
    for (int k = 0; k < DV_N; k++) begin
      if (k == 0) begin
        den_i = in_den;
        rem_i = '0;
        qd_i  = in_num;
      end else begin
        den_i = den_r[k-1];
        rem_i = rem_r[k-1];
        qd_i  = qd_r[k-1];
      end
      // dividend shifts out at the top, quotient shifts in at the bottom
      t = {rem_i, qd_i[NUM_W-1]};
      if (t >= {1'b0, den_i}) begin
        rem_nxt[k] = R_W'(t - {1'b0, den_i});
        qd_nxt[k]  = {qd_i[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt[k] = t[R_W-1:0];
        qd_nxt[k]  = {qd_i[NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DV_N; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int k = 1; k < DV_N; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      den_r[0]  <= in_den;
      for (int k = 1; k < DV_N; k++) begin
        side_r[k] <= side_r[k-1];
        den_r[k]  <= den_r[k-1];
      end
      for (int k = 0; k < DV_N; k++) begin
        rem_r[k] <= rem_nxt[k];
        qd_r[k]  <= qd_nxt[k];
      end
    end
  end

  assign out_vld  = vld_r[DV_N-1];
  assign out_quot = qd_r[DV_N-1];
  assign out_side = side_r[DV_N-1];

endmodule

// ===== sv/ctpe_checker.sv =====
// Port-level checker for the truncated Coulomb pair energy unit, plus its bind.
// Depends on ctpe_pkg and truncated_coulomb_pair_energy_unit.
module ctpe_checker import ctpe_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input ctpe_out_t         out_data
);

  // a held result does not change until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // requests are only refused while a result is waiting
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("request refused with no result pending");

  // pairs outside the cutoff give a clean zero
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.inside_cutoff |-> out_data.energy == '0 && !out_data.saturated)
    else $error("nonzero result outside cutoff");

  // a clipped energy sits at a limit or is zero (zero distance, zero lB*qa*qb)
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      out_data.energy == E_POS_MAX || out_data.energy == E_NEG_MIN || out_data.energy == '0)
    else $error("saturated energy off limit");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind truncated_coulomb_pair_energy_unit ctpe_checker u_ctpe_checker (.*);
